// File: src/vic_pkg.sv
// Shared types, register offsets and constants for the vectored interrupt controller.
// No dependencies; every other file but vic_checker.sv imports this package.
package vic_pkg;

  localparam int NUM_SOURCES_DEF = 32;
  localparam int LANES           = 32;
  localparam int LANE_IW         = 5;
  localparam int GROUPS          = 4;
  localparam int GROUP_SZ        = LANES / GROUPS;
  localparam int LVL_W           = 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINES = 2'd2;

  localparam logic [11:0] OFS_IRQSTAT = 12'h000;
  localparam logic [11:0] OFS_FIQSTAT = 12'h004;
  localparam logic [11:0] OFS_RAW     = 12'h008;
  localparam logic [11:0] OFS_SELECT  = 12'h00C;
  localparam logic [11:0] OFS_ENSET   = 12'h010;
  localparam logic [11:0] OFS_ENCLR   = 12'h014;
  localparam logic [11:0] OFS_SOFTSET = 12'h018;
  localparam logic [11:0] OFS_SOFTCLR = 12'h01C;
  localparam logic [11:0] OFS_PROTECT = 12'h020;
  localparam logic [11:0] OFS_LMASK   = 12'h024;
  localparam logic [11:0] OFS_DAISY   = 12'h028;
  localparam logic [11:0] OFS_VADDR   = 12'hF00;
  localparam logic [11:0] OFS_ID_LO   = 12'hFE0;

  // offset[11:7] of the vector and priority table windows
  localparam logic [4:0] VEC_WIN = 5'b00010;
  localparam logic [4:0] PRI_WIN = 5'b00100;

  localparam logic [7:0] ID_BYTES [8] = '{8'h92, 8'h11, 8'h04, 8'h00,
                                          8'h0D, 8'hF0, 8'h05, 8'hB1};

  localparam logic [15:0]      LMASK_RST = 16'hFFFF;
  localparam logic [LVL_W-1:0] LVL_RST   = 4'hF;

  typedef struct packed {
    logic               act;
    logic [LVL_W-1:0]   lvl;
    logic [LANE_IW-1:0] idx;
  } node_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit_direct;
    logic pick;
    logic emit_mem;
  } ctl_cmd_t;

  typedef struct packed {
    logic needs_mem;
    logic is_vaddr;
  } ctl_sts_t;

  // b has the higher index: take it only on a strictly lower priority value
  function automatic node_t pick2(input node_t a, input node_t b);
    node_t r;
    r = a;
    if (b.act && (!a.act || (b.lvl < a.lvl))) r = b;
    return r;
  endfunction

endpackage

// File: src/vic_ctrl.sv
// Sequencer for the interrupt controller: accepts a word and steps the datapath.
// Depends on vic_pkg for the command and status structs.
module vic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  vic_pkg::ctl_sts_t sts,
  output vic_pkg::ctl_cmd_t cmd,
  output logic              busy
);
  import vic_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_PICK  = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (!sts.needs_mem)   state_nxt = ST_IDLE;
        else if (sts.is_vaddr) state_nxt = ST_PICK;
        else                  state_nxt = ST_FINAL;
      end
      ST_PICK:  state_nxt = ST_FINAL;
      ST_FINAL: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign cmd.load        = (state_r == ST_IDLE) && start;
  assign cmd.exec        = (state_r == ST_EXEC);
  assign cmd.emit_direct = (state_r == ST_EXEC) && !sts.needs_mem;
  assign cmd.pick        = (state_r == ST_PICK);
  assign cmd.emit_mem    = (state_r == ST_FINAL);

endmodule

// File: src/vic_datapath.sv
// Register file, vector table memory, priority compare tree and result register.
// Depends on vic_pkg; driven by vic_ctrl through ctl_cmd_t.
module vic_datapath #(
  parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vic_pkg::ctl_cmd_t cmd,
  output vic_pkg::ctl_sts_t sts,
  input  logic [1:0]        in_command,
  input  logic [11:0]       in_offset,
  input  logic [31:0]       in_write_data,
  input  logic [31:0]       in_line_levels,
  output logic              out_strobe,
  output logic [31:0]       out_read_data,
  output logic              out_unmapped
);
  import vic_pkg::*;

  localparam int IW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam logic [5:0] NS_W = 6'(NUM_SOURCES);

  // captured word
  logic [1:0]  cmd_r;
  logic [11:0] ofs_r;
  logic [31:0] wd_r, lv_r;

  // architectural state
  logic [NUM_SOURCES-1:0] raw_r, fiq_r, en_r, soft_r;
  logic                   prot_r;
  logic [15:0]            lmask_r;
  logic [LVL_W-1:0]       daisy_r;
  logic [LVL_W-1:0]       lvl_r [NUM_SOURCES];
  logic [31:0]            last_vec_r;
  logic [31:0]            vt_mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] vt_valid_r;

  logic [31:0] vt_q_r;
  logic        vt_qv_r;
  node_t       grp_r [GROUPS];
  logic        win_act_r;

  logic        out_strobe_r;
  logic [31:0] out_read_data_r;
  logic        out_unmapped_r;

  // decode
  logic [4:0]             tbl_idx;
  logic                   idx_ok, vt_hit, pri_hit, id_hit, is_rd, is_wr;
  logic [NUM_SOURCES-1:0] pend;
  logic [31:0]            rd_val;
  logic                   mapped;
  logic [31:0]            vt_data;
  logic [LANES-1:0]       act_ext;
  node_t                  lane [LANES];
  node_t                  grp_nxt [GROUPS];
  node_t                  win;
  logic [IW-1:0]          rd_addr;

  assign tbl_idx = ofs_r[6:2];
  assign idx_ok  = ({1'b0, tbl_idx} < NS_W);
  assign vt_hit  = (ofs_r[11:7] == VEC_WIN);
  assign pri_hit = (ofs_r[11:7] == PRI_WIN);
  assign id_hit  = (ofs_r >= OFS_ID_LO) && (ofs_r[1:0] == 2'b00);
  assign is_rd   = (cmd_r == CMD_READ);
  assign is_wr   = (cmd_r == CMD_WRITE);
  assign pend    = (raw_r | soft_r) & en_r;

  assign sts.is_vaddr  = is_rd && (ofs_r == OFS_VADDR);
  assign sts.needs_mem = is_rd && ((vt_hit && idx_ok) || (ofs_r == OFS_VADDR));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      ofs_r <= in_offset;
      wd_r  <= in_write_data;
      lv_r  <= in_line_levels;
    end
  end

  // register read mux
  always_comb begin
    rd_val = '0;
    mapped = 1'b1;
    if (vt_hit) begin
      mapped = idx_ok;
    end else if (pri_hit) begin
      mapped = idx_ok;
      if (idx_ok) rd_val = 32'(lvl_r[tbl_idx[IW-1:0]]);
    end else if (id_hit) begin
      rd_val = 32'(ID_BYTES[ofs_r[4:2]]);
    end else begin
      unique case (ofs_r)
        OFS_IRQSTAT: rd_val = 32'(pend & ~fiq_r);
        OFS_FIQSTAT: rd_val = 32'(pend & fiq_r);
        OFS_RAW:     rd_val = 32'(raw_r | soft_r);
        OFS_SELECT:  rd_val = 32'(fiq_r);
        OFS_ENSET:   rd_val = 32'(en_r);
        OFS_SOFTSET: rd_val = 32'(soft_r);
        OFS_PROTECT: rd_val = 32'(prot_r);
        OFS_LMASK:   rd_val = 32'(lmask_r);
        OFS_DAISY:   rd_val = 32'(daisy_r);
        OFS_ENCLR, OFS_SOFTCLR, OFS_VADDR: rd_val = '0;
        default:     mapped = 1'b0;
      endcase
    end
  end

  // register writes and line loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r   <= '0;
      fiq_r   <= '0;
      en_r    <= '0;
      soft_r  <= '0;
      prot_r  <= 1'b0;
      lmask_r <= LMASK_RST;
      daisy_r <= LVL_RST;
      for (int i = 0; i < NUM_SOURCES; i++) lvl_r[i] <= LVL_RST;
    end else if (cmd.exec) begin
      if (cmd_r == CMD_LINES) begin
        raw_r <= lv_r[NUM_SOURCES-1:0];
      end else if (is_wr) begin
        if (pri_hit && idx_ok) lvl_r[tbl_idx[IW-1:0]] <= wd_r[LVL_W-1:0];
        if (!vt_hit && !pri_hit && !id_hit) begin
          unique case (ofs_r)
            OFS_SELECT:  fiq_r   <= wd_r[NUM_SOURCES-1:0];
            OFS_ENSET:   en_r    <= en_r | wd_r[NUM_SOURCES-1:0];
            OFS_ENCLR:   en_r    <= en_r & ~wd_r[NUM_SOURCES-1:0];
            OFS_SOFTSET: soft_r  <= soft_r | wd_r[NUM_SOURCES-1:0];
            OFS_SOFTCLR: soft_r  <= soft_r & ~wd_r[NUM_SOURCES-1:0];
            OFS_PROTECT: prot_r  <= wd_r[0];
            OFS_LMASK:   lmask_r <= wd_r[15:0];
            OFS_DAISY:   daisy_r <= wd_r[LVL_W-1:0];
            default:     ;
          endcase
        end
      end
    end
  end

  // vector table: one write port, one registered read port
  assign rd_addr = cmd.pick ? win.idx[IW-1:0] : tbl_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.exec && is_wr && vt_hit && idx_ok) vt_mem[tbl_idx[IW-1:0]] <= wd_r;
    if (cmd.exec || cmd.pick) begin
      vt_q_r  <= vt_mem[rd_addr];
      vt_qv_r <= vt_valid_r[rd_addr];
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) vt_valid_r <= '0;
    else if (cmd.exec && is_wr && vt_hit && idx_ok) vt_valid_r[tbl_idx[IW-1:0]] <= 1'b1;
  end

  assign vt_data = vt_qv_r ? vt_q_r : '0;

  // priority tree, first level: eight lanes per group
  assign act_ext = LANES'(pend & ~fiq_r);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < NUM_SOURCES) begin : g_src
      assign lane[i] = '{act: act_ext[i], lvl: lvl_r[i], idx: LANE_IW'(i)};
    end else begin : g_pad
      assign lane[i] = '{act: 1'b0, lvl: LVL_RST, idx: LANE_IW'(i)};
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = lane[g*GROUP_SZ];
      for (int j = 1; j < GROUP_SZ; j++) grp_nxt[g] = pick2(grp_nxt[g], lane[g*GROUP_SZ+j]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) grp_r <= grp_nxt;
  end

  // second level: fold the group winners
  always_comb begin
    win = grp_r[0];
    for (int g = 1; g < GROUPS; g++) win = pick2(win, grp_r[g]);
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) win_act_r <= win.act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) last_vec_r <= '0;
    else if (cmd.emit_mem && sts.is_vaddr && win_act_r) last_vec_r <= vt_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= cmd.emit_direct || cmd.emit_mem;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_direct) begin
      out_read_data_r <= is_rd ? rd_val : '0;
      out_unmapped_r  <= (is_rd || is_wr) && !mapped;
    end else if (cmd.emit_mem) begin
      out_read_data_r <= (sts.is_vaddr && !win_act_r) ? last_vec_r : vt_data;
      out_unmapped_r  <= 1'b0;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_read_data = out_read_data_r;
  assign out_unmapped  = out_unmapped_r;

endmodule

// File: src/vectored_interrupt_controller_unit.sv
// Register access, line updates and a strobe per result word; receiver cannot stall.
// Path from acceptance to the result strobe: plain registers, writes and line loads go
// through EXEC; vector table reads through EXEC and FINAL (registered table read); the
// vector address register through EXEC, PICK and FINAL (two-level priority compare tree,
// then the table read). A new word is taken in the cycle busy drops, after the last is done.
// Synchronous active-low reset inits the register file; table reads zero via valid bits.
module vectored_interrupt_controller_unit #(
  parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_line_levels,
  output logic        out_strobe,
  output logic [31:0] out_read_data,
  output logic        out_unmapped
);
  import vic_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  vic_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  vic_datapath #(.NUM_SOURCES(NUM_SOURCES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_command),
    .in_offset      (in_offset),
    .in_write_data  (in_write_data),
    .in_line_levels (in_line_levels),
    .out_strobe     (out_strobe),
    .out_read_data  (out_read_data),
    .out_unmapped   (out_unmapped)
  );

endmodule

// File: src/vic_checker.sv
// Port-level checks on the interrupt controller's timing, bound to the top level.
// Depends only on the top level's port names.
module vic_port_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted word");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe)
    else $error("result strobe in the cycle right after acceptance");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

  a_busy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy ##1 busy ##1 busy |=> !busy)
    else $error("busy held longer than three cycles");

endmodule

bind vectored_interrupt_controller_unit vic_port_checker u_vic_checker (.*);
